>>> rtl/core/tpf_pkg.sv
// shared types and constants for the prefix-free trie checker
`default_nettype none

package tpf_pkg;

   // default sizes of the node store and the alphabet
   localparam int NODE_COUNT_DEF    = 4096;
   localparam int ALPHABET_SIZE_DEF = 10;

   // field widths fixed by the interface
   localparam int LETTER_W  = 4;
   localparam int VERDICT_W = 2;
   localparam int WORD_NUM_W = 16;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_OK    = 2'd0,
      VERDICT_BREAK = 2'd1,
      VERDICT_BAD   = 2'd2,
      VERDICT_FULL  = 2'd3
   } verdict_type;

   typedef enum logic {
      ST_ROW,
      ST_NODE
   } state_type;

   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic                last_letter;
   } req_type;

   typedef struct packed {
      logic [VERDICT_W-1:0]  verdict;
      logic [WORD_NUM_W-1:0] word_number;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/trie_prefix_free_check.sv
// prefix-free word set checker built on a trie held in two node memories
`default_nettype none

// Words arrive one letter per transfer, the last letter flagged; each word gives one
// verdict on its last letter (accepted, breaks the prefix rule, set already bad, store
// full), bad and full being sticky. For each letter the row state picks the child entry
// from the cursor node's row, read from the row memory, and issues the read of that
// child's record from the node memory; the node state then checks the record and
// issues the next letter's row read, and no new letter is taken in the node state.
// Each node's record holds its parent node and letter plus its end mark, and a child
// entry counts only when it is nonzero, below the count of nodes in use and its record
// names the same parent and letter; the memories therefore need no clearing pass and
// the block accepts letters straight after reset. A letter code at or above the
// alphabet size is taken as the last letter of the alphabet.
module trie_prefix_free_check #(
   parameter int NODE_COUNT    = tpf_pkg::NODE_COUNT_DEF,
   parameter int ALPHABET_SIZE = tpf_pkg::ALPHABET_SIZE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tpf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tpf_pkg::rsp_type rsp_data
);

   import tpf_pkg::*;

   localparam int NW = $clog2(NODE_COUNT);
   localparam int LW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int RW = ALPHABET_SIZE * NW;

   typedef struct packed {
      logic          end_word;
      logic [NW-1:0] parent;
      logic [LW-1:0] letter;
   } node_type;

   // memories
   logic [RW-1:0] row_mem  [NODE_COUNT];
   node_type      node_mem [NODE_COUNT];

   logic [RW-1:0] row_rd_ff;
   node_type      node_rd_ff;

   // control and walk state
   state_type            state_ff, state_in;
   logic [NW-1:0]        cursor_ff, cursor_in;
   logic [NW:0]          niu_ff, niu_in;
   logic                 word_failed_ff, word_failed_in;
   logic                 set_bad_ff, set_bad_in;
   logic                 store_full_ff, store_full_in;
   logic [WORD_NUM_W-1:0] words_ff, words_in;
   logic [LW-1:0]        letter_ff, letter_in;
   logic                 last_ff, last_in;
   logic [NW-1:0]        entry_ff, entry_in;
   logic                 fwd_ff, fwd_in;
   logic [RW-1:0]        fwd_row_ff, fwd_row_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic [LW-1:0]        letter_idx;
   logic [RW-1:0]        row_q;
   logic [NW-1:0]        entry_sel;
   logic                 hit;
   logic                 walk;
   logic                 row_we;
   logic [RW-1:0]        row_wdata;
   logic                 node_we;
   node_type             node_wdata;
   logic                 produce;
   verdict_type          verdict;

   // letter saturation and row selection
   assign letter_idx = (int'(req_data.letter) >= ALPHABET_SIZE - 1) ?
                       LW'(ALPHABET_SIZE - 1) : LW'(req_data.letter);
   assign row_q      = fwd_ff ? fwd_row_ff : row_rd_ff;
   assign entry_sel  = row_q[letter_idx * NW +: NW];
   assign accept     = req_valid && req_ready;

   // a stored child counts only when its record points back here
   assign hit = (entry_ff != '0) && ({1'b0, entry_ff} < niu_ff) &&
                (node_rd_ff.parent == cursor_ff) && (node_rd_ff.letter == letter_ff);
   assign walk = !set_bad_ff && !store_full_ff && !word_failed_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ROW: begin
            if (accept) begin
               state_in = ST_NODE;
            end
         end
         ST_NODE: begin
            state_in = ST_ROW;
         end
         default: begin
            state_in = ST_ROW;
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      req_ready = 1'b0;
      case (state_ff)
         ST_ROW: begin
            req_ready = !rsp_valid_ff || rsp_ready || !req_data.last_letter;
         end
         ST_NODE: begin
            req_ready = 1'b0;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // child row with the current letter pointing at the new node
   always_comb begin
      row_wdata = row_q;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         if (letter_ff == LW'(i)) begin
            row_wdata[i * NW +: NW] = niu_ff[NW-1:0];
         end
      end
   end

   // walk step, allocation and verdict
   always_comb begin
      cursor_in      = cursor_ff;
      niu_in         = niu_ff;
      word_failed_in = word_failed_ff;
      set_bad_in     = set_bad_ff;
      store_full_in  = store_full_ff;
      words_in       = words_ff;
      letter_in      = letter_ff;
      last_in        = last_ff;
      entry_in       = entry_ff;
      row_we         = 1'b0;
      node_we        = 1'b0;
      node_wdata     = '{end_word: last_ff, parent: cursor_ff, letter: letter_ff};
      produce        = 1'b0;
      verdict        = VERDICT_OK;

      if (state_ff == ST_ROW && accept) begin
         letter_in = letter_idx;
         last_in   = req_data.last_letter;
         entry_in  = entry_sel;
      end

      if (state_ff == ST_NODE) begin
         if (walk) begin
            if (hit) begin
               if (node_rd_ff.end_word || last_ff) begin
                  word_failed_in = 1'b1;
               end else begin
                  cursor_in = entry_ff;
               end
            end else if (niu_ff >= (NW+1)'(NODE_COUNT)) begin
               store_full_in = 1'b1;
            end else begin
               row_we    = 1'b1;
               node_we   = 1'b1;
               cursor_in = niu_ff[NW-1:0];
               niu_in    = niu_ff + 1'b1;
            end
         end

         if (last_ff) begin
            produce = 1'b1;
            if (set_bad_ff) begin
               verdict = VERDICT_BAD;
            end else if (store_full_in) begin
               verdict = VERDICT_FULL;
            end else if (word_failed_in) begin
               verdict    = VERDICT_BREAK;
               set_bad_in = 1'b1;
            end else begin
               verdict = VERDICT_OK;
            end
            if (words_ff != '1) begin
               words_in = words_ff + 1'b1;
            end
            cursor_in      = '0;
            word_failed_in = 1'b0;
         end
      end
   end

   // forward a row written at the address being read
   assign fwd_in     = row_we && (cursor_in == cursor_ff);
   assign fwd_row_in = row_wdata;

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (produce) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{verdict: verdict, word_number: words_ff};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // row memory: read at the next cursor every cycle
   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[cursor_ff] <= row_wdata;
      end
      row_rd_ff <= row_mem[cursor_in];
   end

   // node memory: records written on allocation
   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[niu_ff[NW-1:0]] <= node_wdata;
      end
      if (accept) begin
         node_rd_ff <= node_mem[entry_sel];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_ROW;
         cursor_ff      <= '0;
         niu_ff         <= (NW+1)'(1);
         word_failed_ff <= 1'b0;
         set_bad_ff     <= 1'b0;
         store_full_ff  <= 1'b0;
         words_ff       <= '0;
         fwd_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cursor_ff      <= cursor_in;
         niu_ff         <= niu_in;
         word_failed_ff <= word_failed_in;
         set_bad_ff     <= set_bad_in;
         store_full_ff  <= store_full_in;
         words_ff       <= words_in;
         fwd_ff         <= fwd_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      letter_ff   <= letter_in;
      last_ff     <= last_in;
      entry_ff    <= entry_in;
      fwd_row_ff  <= fwd_row_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the prefix-free trie checker
`default_nettype none

module testbench;
   import tpf_pkg::*;

   localparam int NODES      = NODE_COUNT_DEF;
   localparam int ALPHA      = ALPHABET_SIZE_DEF;
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_PRINTS = 200;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   trie_prefix_free_check u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // predicted trie state
   logic [15:0] trie_child [NODES*ALPHA];
   bit          word_end [NODES];
   int unsigned walk_node;
   int unsigned nodes_used;
   bit          word_broken;
   bit          set_broken;
   bit          store_exhausted;
   int unsigned word_count;

   // verdicts still owed by the block, oldest first
   rsp_type     pending_verdicts [$];
   logic [3:0]  word_buf [$];

   int unsigned error_count = 0;
   int unsigned letters_sent = 0;
   int unsigned burst_left;
   int unsigned max_gap;
   int unsigned hold_asks = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // trie state after reset
   task clear_model();
      for (int i = 0; i < NODES*ALPHA; i++) trie_child[i] = '0;
      for (int i = 0; i < NODES; i++) word_end[i] = 1'b0;
      walk_node       = 0;
      nodes_used      = 1;
      word_broken     = 1'b0;
      set_broken      = 1'b0;
      store_exhausted = 1'b0;
      word_count      = 0;
   endtask

   // walk one letter into the trie and give the verdict on a last letter
   function automatic void walk_trie(input logic [3:0] code, input bit last,
                                     output bit has_verdict, output rsp_type verdict_out);
      int unsigned ltr;
      int unsigned slot;
      int unsigned child;
      verdict_type v;
      ltr = (code >= ALPHA) ? ALPHA - 1 : code;
      has_verdict = 1'b0;
      verdict_out = '0;
      if (!set_broken && !store_exhausted && !word_broken) begin
         slot  = walk_node * ALPHA + ltr;
         child = trie_child[slot];
         if (child == 0) begin
            if (nodes_used >= NODES) begin
               store_exhausted = 1'b1;
            end else begin
               trie_child[slot] = 16'(nodes_used);
               walk_node = nodes_used;
               nodes_used++;
            end
         end else if (word_end[child] || last) begin
            word_broken = 1'b1;
         end else begin
            walk_node = child;
         end
      end
      if (last) begin
         if (set_broken) begin
            v = VERDICT_BAD;
         end else if (store_exhausted) begin
            v = VERDICT_FULL;
         end else if (word_broken) begin
            v = VERDICT_BREAK;
            set_broken = 1'b1;
         end else begin
            v = VERDICT_OK;
            word_end[walk_node] = 1'b1;
         end
         verdict_out.verdict     = v;
         verdict_out.word_number = word_count[15:0];
         if (word_count < 16'hFFFF) word_count++;
         walk_node   = 0;
         word_broken = 1'b0;
         has_verdict = 1'b1;
      end
   endfunction

   // would the word in word_buf break the prefix rule against the present trie
   function automatic bit word_clashes();
      int unsigned node;
      int unsigned ltr;
      int unsigned child;
      node = 0;
      for (int i = 0; i < word_buf.size(); i++) begin
         ltr   = (word_buf[i] >= ALPHA) ? ALPHA - 1 : word_buf[i];
         child = trie_child[node * ALPHA + ltr];
         if (child == 0) return 1'b0;
         if (word_end[child] || i == word_buf.size() - 1) return 1'b1;
         node = child;
      end
      return 1'b0;
   endfunction

   // one letter transfer, with bursts and random gaps in between
   task send_letter(input logic [3:0] code, input bit last);
      int unsigned gap;
      bit          has_verdict;
      rsp_type     verdict_out;
      if (burst_left == 0) begin
         gap = $urandom_range(0, max_gap);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            req_data  <= req_type'($bits(req_type)'($urandom));
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= '{letter: code, last_letter: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      letters_sent++;
      walk_trie(code, last, has_verdict, verdict_out);
      if (has_verdict) pending_verdicts.push_back(verdict_out);
   endtask

   task send_word();
      for (int i = 0; i < word_buf.size(); i++) begin
         send_letter(word_buf[i], i == word_buf.size() - 1);
      end
   endtask

   // random letters, now and then a code above the alphabet
   task make_random_word(input int unsigned lo, input int unsigned hi);
      int unsigned len;
      word_buf.delete();
      len = $urandom_range(lo, hi);
      repeat (len) begin
         if ($urandom_range(0, 7) == 0) word_buf.push_back(4'($urandom_range(ALPHA, 15)));
         else word_buf.push_back(4'($urandom_range(0, ALPHA - 1)));
      end
   endtask

   // random word meant to keep the set prefix-free, longer after every eight retries
   task make_fresh_word(input int unsigned lo, input int unsigned hi);
      for (int tries = 0; tries < 40; tries++) begin
         make_random_word(lo + tries / 8, hi + tries / 8);
         if (!word_clashes()) break;
      end
   endtask

   // extremes of the letter codes, shared prefixes and branching
   task test_directed_words();
      send_letter(4'd0, 1'b0);  send_letter(4'd15, 1'b1);
      send_letter(4'd9, 1'b0);  send_letter(4'd0, 1'b0);  send_letter(4'd10, 1'b1);
      send_letter(4'd12, 1'b0); send_letter(4'd1, 1'b0);  send_letter(4'd13, 1'b1);
      send_letter(4'd14, 1'b0); send_letter(4'd0, 1'b0);  send_letter(4'd0, 1'b1);
      send_letter(4'd3, 1'b0);  send_letter(4'd4, 1'b0);  send_letter(4'd5, 1'b0);
      send_letter(4'd6, 1'b0);  send_letter(4'd7, 1'b0);  send_letter(4'd8, 1'b1);
      send_letter(4'd2, 1'b0);  send_letter(4'd11, 1'b1);
      send_letter(4'd0, 1'b0);  send_letter(4'd0, 1'b1);
   endtask

   task test_random_words(input int unsigned letter_count);
      int unsigned stop_at;
      stop_at = letters_sent + letter_count;
      while (letters_sent < stop_at) begin
         make_fresh_word(2, 7);
         send_word();
      end
   endtask

   // receiver holds off while short words keep coming, so the block backs up
   task test_input_stall();
      int unsigned stop_at;
      hold_asks++;
      stop_at = letters_sent + 40;
      while (letters_sent < stop_at) begin
         make_fresh_word(2, 3);
         send_word();
      end
   endtask

   // the three kinds of conflict against the word j a j
   task send_conflict(input int unsigned kind);
      case (kind)
         0: begin
            // equal word
            send_letter(4'd9, 1'b0); send_letter(4'd0, 1'b0); send_letter(4'd9, 1'b1);
         end
         1: begin
            // prefix of an earlier word
            send_letter(4'd9, 1'b0); send_letter(4'd0, 1'b1);
         end
         default: begin
            // passes an end mark, the rest of the word is ignored
            send_letter(4'd9, 1'b0); send_letter(4'd0, 1'b0); send_letter(4'd10, 1'b0);
            send_letter(4'd3, 1'b0); send_letter(4'd15, 1'b1);
         end
      endcase
   endtask

   task test_prefix_conflict();
      send_conflict($urandom_range(0, 2));
      for (int i = 0; i < 3; i++) send_conflict(i);
      repeat (10) begin
         make_random_word(1, 6);
         send_word();
      end
   endtask

   // receiver stall pattern, with a long hold-off on request
   initial begin
      int unsigned pace_mode;
      int unsigned pace_count;
      int unsigned hold_left;
      int unsigned hold_done;
      rsp_ready  = 1'b0;
      pace_mode  = 0;
      pace_count = 0;
      hold_left  = 0;
      hold_done  = 0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = hold_asks;
         end
         if (pace_count == 0) begin
            pace_mode  = $urandom_range(0, 3);
            pace_count = $urandom_range(20, 120);
         end
         pace_count--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (pace_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= $urandom_range(0, 1);
               2: rsp_ready <= ($urandom_range(0, 9) != 0);
               default: rsp_ready <= (pace_count % 3 != 0);
            endcase
         end
      end
   end

   // compare each verdict transfer with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            if (error_count < MAX_PRINTS)
               $display("%0t: unexpected verdict %0d word_number %0d", $time,
                        rsp_data.verdict, rsp_data.word_number);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_data.verdict !== want.verdict) begin
               if (error_count < MAX_PRINTS)
                  $display("%0t: verdict mismatch on word %0d, expected %0d, actual %0d",
                           $time, want.word_number, want.verdict, rsp_data.verdict);
               error_count++;
            end
            if (rsp_data.word_number !== want.word_number) begin
               if (error_count < MAX_PRINTS)
                  $display("%0t: word_number mismatch, expected %0d, actual %0d",
                           $time, want.word_number, rsp_data.word_number);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // test sequence
   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      burst_left = 0;
      max_gap    = 6;
      clear_model();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_words();
      test_random_words(170);
      test_input_stall();
      test_random_words(170);
      test_prefix_conflict();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
